@@ hw/rtl/assert_macros.svh @@
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// checked at every rising clock edge, held off while reset is low
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ hw/rtl/bojl_pkg.sv @@
`default_nettype none

package bojl_pkg;

    localparam int MAX_JOBS_DEF = 16;
    localparam int ID_BITS_DEF  = 16;

    localparam int JOB_ID_W   = 16;
    localparam int POSITION_W = 6;
    localparam int POS_W      = 5;
    localparam int CAP_W      = 5;
    localparam int CNT_OUT_W  = 5;
    localparam int STATUS_W   = 3;
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 8;

    localparam logic [CAP_W-1:0]      CAP_RESET  = 5'd16;
    localparam logic [POSITION_W-1:0] POS_APPEND = 6'h3F;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_APPENDED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_DELETED   = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_NOT_FOUND = 3'd5
    } status_t;

    typedef enum logic {
        B_IDLE  = 1'b0,
        B_APPLY = 1'b1
    } back_state_t;

    // decoded request as it sits in the queue
    typedef struct packed {
        logic             is_delete;
        logic             from_head;
        logic             tail;
        logic             neg;
        logic [POS_W-1:0] pos;
    } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/bounded_ordered_job_list_core.sv @@
`default_nettype none

// channel   dir  tdata                               tuser
// s_        in   [15:0] job_id, [21:16] position     [0] req_type, [1] from_head
// m_        out  [4:0] count                         [2:0] status
// cfg_      in   cfg_wr_data[4:0] capacity, written when cfg_wr_en is high
//
// an insert is carried out in the cycle it leaves the queue; a delete first compares
// every slot against the id and registers the hits, then shifts in B_APPLY once the output is free
// a beat passes the command queue and then the result register; a delete also passes the match register
// a two-entry command queue sits between the decoder and the list, so input and output stall apart
// aresetn (synchronous) empties the list and sets capacity to 16; slot contents are not cleared

module bounded_ordered_job_list_core #(
    parameter int MAX_JOBS = bojl_pkg::MAX_JOBS_DEF,
    parameter int ID_BITS  = bojl_pkg::ID_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bojl_pkg::S_TDATA_W-1:0] s_tdata,   // job_id, position, zero pad
    input  wire logic [bojl_pkg::S_TUSER_W-1:0] s_tuser,   // req_type, from_head
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bojl_pkg::M_TDATA_W-1:0]      m_tdata,   // count, zero pad
    output logic [bojl_pkg::STATUS_W-1:0]       m_tuser,   // status
    input  wire logic                           cfg_wr_en,
    input  wire logic [bojl_pkg::CAP_W-1:0]     cfg_wr_data
);

    logic [bojl_pkg::CAP_W-1:0] capacity_reg;

    logic               q_full, q_push, q_valid, q_pop;
    bojl_pkg::cmd_t     push_cmd, head_cmd;
    logic [ID_BITS-1:0] push_id, head_id;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= bojl_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    bojl_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd),
        .q_id     (push_id)
    );

    bojl_queue #(
        .ID_BITS (ID_BITS)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_id    (push_id),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (head_cmd),
        .head_id    (head_id),
        .pop        (q_pop)
    );

    bojl_back #(
        .MAX_JOBS (MAX_JOBS),
        .ID_BITS  (ID_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .capacity (capacity_reg),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_id     (head_id),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

@@ hw/rtl/bojl_front.sv @@
`default_nettype none

module bojl_front #(
    parameter int ID_BITS = bojl_pkg::ID_BITS_DEF
) (
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bojl_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [bojl_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire logic                           q_full,
    output logic                                q_push,
    output bojl_pkg::cmd_t                      q_cmd,
    output logic [ID_BITS-1:0]                  q_id
);

    logic [bojl_pkg::JOB_ID_W-1:0]   job_id;
    logic [bojl_pkg::POSITION_W-1:0] position;

    assign job_id   = s_tdata[bojl_pkg::JOB_ID_W-1:0];
    assign position = s_tdata[bojl_pkg::JOB_ID_W +: bojl_pkg::POSITION_W];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // only the low ID_BITS of the id take part
    assign q_id = ID_BITS'(job_id);

    always_comb begin
        q_cmd.is_delete = s_tuser[0];
        q_cmd.from_head = s_tuser[1];
        q_cmd.tail      = (position == bojl_pkg::POS_APPEND);
        // any other negative position appends as out of range
        q_cmd.neg       = position[bojl_pkg::POSITION_W-1] && !q_cmd.tail;
        q_cmd.pos       = position[bojl_pkg::POS_W-1:0];
    end

endmodule

`default_nettype wire

@@ hw/rtl/bojl_queue.sv @@
`default_nettype none

module bojl_queue #(
    parameter int ID_BITS = bojl_pkg::ID_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire bojl_pkg::cmd_t       push_cmd,
    input  wire logic [ID_BITS-1:0]   push_id,
    output logic                      full,
    output logic                      head_valid,
    output bojl_pkg::cmd_t            head_cmd,
    output logic [ID_BITS-1:0]        head_id,
    input  wire logic                 pop
);

    bojl_pkg::cmd_t                 cmd_mem [bojl_pkg::Q_DEPTH];
    logic [ID_BITS-1:0]             id_mem  [bojl_pkg::Q_DEPTH];
    logic [bojl_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bojl_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bojl_pkg::Q_CNT_W-1:0]   fill_reg, fill_next;
    logic                           do_push, do_pop;

    assign full       = (fill_reg == bojl_pkg::Q_CNT_W'(bojl_pkg::Q_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = cmd_mem[rd_ptr_reg];
    assign head_id    = id_mem[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            cmd_mem[wr_ptr_reg] <= push_cmd;
            id_mem[wr_ptr_reg]  <= push_id;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bojl_back.sv @@
`default_nettype none
`include "assert_macros.svh"

module bojl_back #(
    parameter int MAX_JOBS = bojl_pkg::MAX_JOBS_DEF,
    parameter int ID_BITS  = bojl_pkg::ID_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [bojl_pkg::CAP_W-1:0]     capacity,
    input  wire logic                           q_valid,
    input  wire bojl_pkg::cmd_t                 q_cmd,
    input  wire logic [ID_BITS-1:0]             q_id,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bojl_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [bojl_pkg::STATUS_W-1:0]       m_tuser
);

    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int CMP_W = (CNT_W > bojl_pkg::POS_W) ? CNT_W : bojl_pkg::POS_W;

    bojl_pkg::back_state_t st_reg, st_next;

    logic [ID_BITS-1:0]  slot_reg [MAX_JOBS];
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [MAX_JOBS-1:0] match_reg, match_next;
    logic                from_head_reg;

    logic                            m_valid_reg;
    bojl_pkg::status_t               status_reg;
    logic [bojl_pkg::CNT_OUT_W-1:0]  cnt_out_reg;

    logic out_free, do_ins, do_scan, do_del, load;
    logic [CMP_W-1:0] cnt_ext, pos_ext, cap_ext, ins_at;
    logic ins_full, pos_past, ins_ok;
    bojl_pkg::status_t ins_status, del_status, res_status;
    logic [MAX_JOBS-1:0] rm_mask;
    logic del_found, del_empty, del_ok;

    // control
    always_comb begin
        out_free = !m_valid_reg || m_tready;
        q_pop    = (st_reg == bojl_pkg::B_IDLE) && q_valid && out_free;
        do_ins   = q_pop && !q_cmd.is_delete;
        do_scan  = q_pop && q_cmd.is_delete;
        do_del   = (st_reg == bojl_pkg::B_APPLY) && out_free;
        load     = do_ins || do_del;
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            bojl_pkg::B_IDLE: begin
                if (do_scan) begin
                    st_next = bojl_pkg::B_APPLY;
                end
            end
            bojl_pkg::B_APPLY: begin
                if (out_free) begin
                    st_next = bojl_pkg::B_IDLE;
                end
            end
            default: st_next = bojl_pkg::B_IDLE;
        endcase
    end

    // insert decision
    always_comb begin
        cnt_ext  = CMP_W'(count_reg);
        pos_ext  = CMP_W'(q_cmd.pos);
        cap_ext  = CMP_W'(capacity);
        ins_full = (cnt_ext >= cap_ext) || (count_reg == CNT_W'(MAX_JOBS));
        pos_past = !q_cmd.tail && !q_cmd.neg && (pos_ext > cnt_ext);
        ins_at   = (q_cmd.tail || q_cmd.neg || pos_past) ? cnt_ext : pos_ext;
        ins_ok   = do_ins && !ins_full;
        if (ins_full) begin
            ins_status = bojl_pkg::ST_FULL;
        end else if (q_cmd.neg || pos_past) begin
            ins_status = bojl_pkg::ST_APPENDED;
        end else begin
            ins_status = bojl_pkg::ST_INSERTED;
        end
    end

    // compare every live slot against the id, registered for the delete step
    always_comb begin
        for (int k = 0; k < MAX_JOBS; k++) begin
            match_next[k] = (CNT_W'(k) < count_reg) && (slot_reg[k] == q_id);
        end
    end

    // delete decision: everything from the first hit (or from the head for from_head) onward moves back one slot
    always_comb begin
        logic seen;
        seen = from_head_reg;
        for (int k = 0; k < MAX_JOBS; k++) begin
            seen       = seen | match_reg[k];
            rm_mask[k] = seen;
        end
        del_empty = (count_reg == '0);
        del_found = from_head_reg || (match_reg != '0);
        del_ok    = do_del && !del_empty && del_found;
        if (del_empty) begin
            del_status = bojl_pkg::ST_EMPTY;
        end else if (del_found) begin
            del_status = bojl_pkg::ST_DELETED;
        end else begin
            del_status = bojl_pkg::ST_NOT_FOUND;
        end
    end

    always_comb begin
        res_status = do_del ? del_status : ins_status;
        count_next = count_reg;
        if (ins_ok) begin
            count_next = count_reg + 1'b1;
        end else if (del_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    // one cell per slot, each sees only its neighbors
    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
        localparam int LO = (g == 0) ? 0 : g - 1;
        localparam int HI = (g == MAX_JOBS - 1) ? g : g + 1;
        always_ff @(posedge aclk) begin
            if (ins_ok) begin
                if (CMP_W'(g) > ins_at) begin
                    slot_reg[g] <= slot_reg[LO];
                end else if (CMP_W'(g) == ins_at) begin
                    slot_reg[g] <= q_id;
                end
            end else if (del_ok && rm_mask[g]) begin
                slot_reg[g] <= slot_reg[HI];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= bojl_pkg::B_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg    <= st_next;
            count_reg <= count_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_scan) begin
            match_reg     <= match_next;
            from_head_reg <= q_cmd.from_head;
        end
        if (load) begin
            status_reg  <= res_status;
            cnt_out_reg <= bojl_pkg::CNT_OUT_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = bojl_pkg::M_TDATA_W'(cnt_out_reg);
    assign m_tuser  = status_reg;

    `ASSERT_CLK(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(MAX_JOBS))
    `ASSERT_CLK(a_pop_idle_only, aclk, aresetn, (st_reg != bojl_pkg::B_IDLE) |-> !q_pop)
    `ASSERT_CLK(a_del_drops_one, aclk, aresetn,
        (load && res_status == bojl_pkg::ST_DELETED) |=> (count_reg == $past(count_reg) - 1'b1))
    `ASSERT_CLK(a_refused_keeps_count, aclk, aresetn,
        (load && (res_status == bojl_pkg::ST_FULL || res_status == bojl_pkg::ST_EMPTY ||
                  res_status == bojl_pkg::ST_NOT_FOUND)) |=> $stable(count_reg))
    `ASSERT_CLK(a_result_count, aclk, aresetn,
        load |=> (cnt_out_reg == bojl_pkg::CNT_OUT_W'(count_reg)))

endmodule

`default_nettype wire

@@ test/bounded_ordered_job_list_checker.sv @@
module bounded_ordered_job_list_checker
    import bojl_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,     // job_id, position, zero pad
    input  logic [S_TUSER_W-1:0]    s_tuser,     // req_type, from_head
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_W-1:0]    m_tdata,     // count, zero pad
    input  logic [STATUS_W-1:0]     m_tuser,     // status
    input  logic                    cfg_wr_en,
    input  logic [CAP_W-1:0]        cfg_wr_data,
    output int                      mismatches,
    output int                      outstanding,
    output int                      results_seen,
    output logic [7:0]              status_seen
);

    typedef struct packed {
        status_t                status;
        logic [CNT_OUT_W-1:0]   count;
    } job_result_t;

    logic [JOB_ID_W-1:0]    job_slots [MAX_JOBS_DEF];
    int                     list_len;
    logic [CAP_W-1:0]       capacity_q;
    job_result_t            expected_results [$];
    int                     fails;

    initial begin
        fails        = 0;
        list_len     = 0;
        capacity_q   = CAP_RESET;
        mismatches   = 0;
        outstanding  = 0;
        results_seen = 0;
        status_seen  = '0;
    end

    // updates the list as the block should and returns the status and count it must report
    function automatic job_result_t apply_request(logic is_delete, logic [JOB_ID_W-1:0] id,
                                                  logic [POSITION_W-1:0] pos, logic head_only);
        job_result_t r;
        int          lim;
        int          at;
        lim = (capacity_q > MAX_JOBS_DEF) ? MAX_JOBS_DEF : int'(capacity_q);
        at  = -1;
        if (!is_delete) begin
            if (list_len >= lim) begin
                r.status = ST_FULL;
            end else begin
                if (pos == POS_APPEND) begin
                    at       = list_len;
                    r.status = ST_INSERTED;
                end else if (pos[POSITION_W-1] || int'(pos) > list_len) begin
                    at       = list_len;
                    r.status = ST_APPENDED;
                end else begin
                    at       = int'(pos);
                    r.status = ST_INSERTED;
                end
                for (int k = list_len; k > at; k--)
                    job_slots[k] = job_slots[k-1];
                job_slots[at] = id;
                list_len++;
            end
        end else begin
            if (list_len == 0) begin
                r.status = ST_EMPTY;
            end else begin
                if (head_only) begin
                    at = 0;
                end else begin
                    for (int k = 0; k < list_len; k++)
                        if (at < 0 && job_slots[k] == id)
                            at = k;
                end
                if (at < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int k = at; k + 1 < list_len; k++)
                        job_slots[k] = job_slots[k+1];
                    list_len--;
                    r.status = ST_DELETED;
                end
            end
        end
        r.count = CNT_OUT_W'(list_len);
        return r;
    endfunction

    always @(posedge aclk) begin
        job_result_t want;
        if (!aresetn) begin
            capacity_q = CAP_RESET;
            list_len   = 0;
            expected_results.delete();
        end else begin
            if (cfg_wr_en)
                capacity_q = cfg_wr_data;
            // result side first: a beat leaving now belongs to an earlier request
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing pending: status %0d count %0d",
                           m_tuser, m_tdata[CNT_OUT_W-1:0]);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    results_seen <= results_seen + 1;
                    status_seen[m_tuser] <= 1'b1;
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fails++;
                    end
                    if (m_tdata[CNT_OUT_W-1:0] !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count,
                               m_tdata[CNT_OUT_W-1:0]);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(s_tuser[0], s_tdata[JOB_ID_W-1:0],
                                                         s_tdata[JOB_ID_W +: POSITION_W],
                                                         s_tuser[1]));
        end
        outstanding <= expected_results.size();
        mismatches  <= fails;
    end

endmodule

@@ test/bounded_ordered_job_list_core_tb.sv @@
module bounded_ordered_job_list_core_tb;
    import bojl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 128;
    localparam int N_PHASES    = 10;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;   // job_id, position, zero pad
    logic [S_TUSER_W-1:0]   s_tuser     = '0;   // req_type, from_head
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;            // count, zero pad
    logic [STATUS_W-1:0]    m_tuser;            // status
    logic                   cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]       cfg_wr_data = '0;

    int                     mismatches;
    int                     outstanding;
    int                     results_seen;
    logic [7:0]             status_seen;

    int                     cycle_count = 0;
    int                     requests_sent = 0;
    int                     tx_gap_odds = 0;
    int                     stall_odds = 0;
    int                     stall_left = 0;
    logic                   calm = 1'b0;
    logic [JOB_ID_W-1:0]    id_pool [8];
    int                     cap_plan [N_PHASES] = '{1, 0, 31, 3, 17, 2, 16, 8, 5, 16};

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bounded_ordered_job_list_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    bounded_ordered_job_list_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .status_seen  (status_seen)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ran out of cycles with %0d results still pending", outstanding);
            $display("bounded_ordered_job_list_core_tb: FAIL");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (!aresetn || calm || stall_odds == 0) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, stall_odds) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_request(logic is_delete, logic [JOB_ID_W-1:0] id,
                                logic [POSITION_W-1:0] pos, logic head_only);
        if (!calm && tx_gap_odds != 0 && $urandom_range(0, tx_gap_odds) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - JOB_ID_W - POSITION_W){1'b0}}, pos, id};
        s_tuser  <= {head_only, is_delete};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    task automatic random_request(int insert_pct);
        logic [JOB_ID_W-1:0]    id;
        logic [POSITION_W-1:0]  pos;
        int                     pick;
        // mostly ids from a small pool so deletes find their targets
        id   = ($urandom_range(0, 3) == 0) ? JOB_ID_W'($urandom) : id_pool[$urandom_range(0, 7)];
        pick = $urandom_range(0, 9);
        if (pick < 3)
            pos = POS_APPEND;
        else if (pick < 7)
            pos = POSITION_W'($urandom_range(0, MAX_JOBS_DEF));
        else if (pick < 9)
            pos = POSITION_W'($urandom_range(MAX_JOBS_DEF + 1, 31));
        else
            pos = POSITION_W'($urandom_range(32, 62));   // negative, not the append code
        push_request($urandom_range(0, 99) >= insert_pct, id, pos, $urandom_range(0, 3) == 0);
    endtask

    // drain everything in flight so the list is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int insert_pct;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int k = 2; k < 8; k++)
            id_pool[k] = JOB_ID_W'($urandom);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty list, every insert position kind, head, middle and tail deletes
        push_request(1'b1, 16'h0000, 6'd0,  1'b0);
        push_request(1'b1, 16'h0000, 6'd0,  1'b1);
        push_request(1'b0, 16'hFFFF, POS_APPEND, 1'b0);
        push_request(1'b0, 16'h0000, 6'd0,  1'b0);
        push_request(1'b0, 16'h1234, 6'd2,  1'b0);
        push_request(1'b0, 16'hABCD, 6'd31, 1'b0);
        push_request(1'b0, 16'h5555, 6'h20, 1'b0);
        push_request(1'b0, 16'hAAAA, 6'h3E, 1'b1);
        push_request(1'b0, 16'h0F0F, 6'd1,  1'b0);
        push_request(1'b0, 16'h1234, 6'd7,  1'b0);
        push_request(1'b1, 16'h0000, 6'd0,  1'b0);
        push_request(1'b1, 16'h1234, 6'h3F, 1'b0);
        push_request(1'b1, 16'h1234, 6'd0,  1'b0);
        push_request(1'b1, 16'hAAAA, 6'd0,  1'b0);
        push_request(1'b1, 16'h7777, 6'd0,  1'b0);
        push_request(1'b1, 16'h5555, 6'd0,  1'b1);
        push_request(1'b1, 16'h0000, 6'd0,  1'b1);
        push_request(1'b1, 16'hFFFF, 6'd0,  1'b1);
        push_request(1'b1, 16'h0000, 6'd0,  1'b1);
        push_request(1'b0, 16'h00FF, 6'd5,  1'b0);
        push_request(1'b1, 16'h0000, 6'd0,  1'b1);
        push_request(1'b0, 16'hFF00, 6'd0,  1'b1);
        push_request(1'b0, 16'h8001, 6'd16, 1'b0);
        settle();

        // each setting ends insert-heavy, so a following smaller one starts over its limit
        for (int p = 0; p < N_PHASES; p++) begin
            set_capacity(CAP_W'(cap_plan[p]));
            tx_gap_odds = $urandom_range(0, 4);
            stall_odds  = $urandom_range(0, 4);
            if (p == N_PHASES - 1)
                calm = 1'b1;
            insert_pct = 50;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 30 == 0)
                    insert_pct = 25 * $urandom_range(1, 3);
                if (i >= PHASE_ITEMS - 30)
                    insert_pct = 80;
                random_request(insert_pct);
            end
            settle();
        end

        repeat (10) @(posedge aclk);
        $display("%0d requests sent over %0d capacity settings, %0d results checked",
                 requests_sent, N_PHASES + 1, results_seen);
        $display("status codes seen (one bit per code, code 0 rightmost): %b", status_seen[5:0]);
        if (mismatches == 0)
            $display("bounded_ordered_job_list_core_tb: PASS");
        else
            $display("bounded_ordered_job_list_core_tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/bojl_pkg.sv
hw/rtl/bojl_front.sv
hw/rtl/bojl_queue.sv
hw/rtl/bojl_back.sv
hw/rtl/bounded_ordered_job_list_core.sv
test/bounded_ordered_job_list_checker.sv
test/bounded_ordered_job_list_core_tb.sv
